// ===== hw/rtl/life_generation_engine_unit_assert.svh =====
// Assertion macros used by the checker of the life generation engine.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef LIFE_GENERATION_ENGINE_UNIT_ASSERT_SVH
`define LIFE_GENERATION_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LGE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LGE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lge_pkg.sv =====
package lge_pkg;

    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int OP_W      = 2;
    localparam int COORD_W   = 6;
    localparam int DIM_W     = 7;
    localparam int POP_W     = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [POP_W-1:0] POP_MAX   = 13'd8191;
    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    // Rows are counted in chunks of eight cells per lane.
    localparam int POP_CHUNK   = 8;
    localparam int POP_CHUNK_W = 4;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_READ    = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CELL,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    // B3/S23: survive on two or three neighbors, birth on exactly three.
    function automatic logic life_rule(logic alive, logic [3:0] n);
        return alive ? ((n == 4'd2) || (n == 4'd3)) : (n == 4'd3);
    endfunction

    function automatic logic [POP_CHUNK_W-1:0] popcount_chunk(logic [POP_CHUNK-1:0] bits);
        logic [POP_CHUNK_W-1:0] s;
        s = '0;
        for (int i = 0; i < POP_CHUNK; i++) begin
            s = s + POP_CHUNK_W'(bits[i]);
        end
        return s;
    endfunction

endpackage

// ===== hw/rtl/lge_in_if.sv =====
interface lge_in_if;
    logic                        valid;
    logic                        ready;
    logic [lge_pkg::OP_W-1:0]    operation;
    logic [lge_pkg::COORD_W-1:0] col;
    logic [lge_pkg::COORD_W-1:0] row;
    logic                        alive;

    modport source (output valid, output operation, output col, output row, output alive,
                    input ready);
    modport sink   (input valid, input operation, input col, input row, input alive,
                    output ready);
endinterface

// ===== hw/rtl/lge_out_if.sv =====
interface lge_out_if;
    logic                      valid;
    logic                      ready;
    logic                      cell_alive;
    logic [lge_pkg::POP_W-1:0] population;

    modport source (output valid, output cell_alive, output population, input ready);
    modport sink   (input valid, input cell_alive, input population, output ready);
endinterface

// ===== hw/rtl/life_generation_engine_unit.sv =====
// Conway life engine (B3/S23) on a bounded grid of MAX_WIDTH x MAX_HEIGHT cells, of which
// the top-left width_in_use x height_in_use area is in use; cells beyond its edges count
// as dead and nothing wraps around. Every command beat gives exactly one response beat
// that carries the population. The grid lives in one row-wide memory with a registered
// read. For a cell write or cell read, the accept cycle launches the row read, and the
// ST_CELL state, once the response register is free, modifies and writes the row back
// and loads the response register. An advance takes the accept cycle, then the sweep,
// which moves one row per cycle through the single read port, then the ST_DRAIN state,
// in which the population pipeline settles. After reset the block first clears the
// memory, one row per cycle, during which no command is accepted; configuration writes
// are taken at any time. A response that waits for the sink does not stop the next
// command from being accepted, but that command holds in its last cycle until the
// response register is free.
module life_generation_engine_unit #(
    parameter int MAX_WIDTH  = lge_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = lge_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lge_in_if.sink                          cmd,
    lge_out_if.source                       rsp,
    input  logic                            cfg_we,
    input  logic [lge_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lge_pkg::DIM_W-1:0]       cfg_data
);

    localparam int RAW   = $clog2(MAX_HEIGHT);
    localparam int CAW   = $clog2(MAX_WIDTH);
    localparam int EW_W  = $clog2(MAX_WIDTH + 1);
    localparam int EH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int SW    = $clog2(MAX_HEIGHT + 2);
    localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    localparam logic [SW-1:0] LAST_CLEAR = SW'(MAX_HEIGHT - 1);
    localparam logic [SW-1:0] LAST_STEP  = SW'(MAX_HEIGHT + 1);

    // Control state.
    lge_pkg::state_t                state_reg;
    lge_pkg::state_t                state_next;
    logic [SW-1:0]                  step_reg;
    logic [SW-1:0]                  step_next;
    logic [lge_pkg::DIM_W-1:0]      width_reg;
    logic [lge_pkg::DIM_W-1:0]      height_reg;
    logic [CNT_W-1:0]               live_cnt_reg;
    logic [CNT_W-1:0]               live_cnt_next;
    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;

    // Payload registers.
    lge_pkg::op_t                   cmd_op_reg;
    logic [lge_pkg::COORD_W-1:0]    cmd_col_reg;
    logic [lge_pkg::COORD_W-1:0]    cmd_row_reg;
    logic                           cmd_alive_reg;
    logic [MAX_WIDTH-1:0]           upper_reg;
    logic [MAX_WIDTH-1:0]           upper_next;
    logic [MAX_WIDTH-1:0]           middle_reg;
    logic [MAX_WIDTH-1:0]           middle_next;
    logic                           rsp_alive_reg;
    logic                           rsp_alive_next;
    logic [lge_pkg::POP_W-1:0]      rsp_pop_reg;
    logic [lge_pkg::POP_W-1:0]      rsp_pop_next;

    // Datapath.
    logic [EW_W-1:0]                eff_w;
    logic [EH_W-1:0]                eff_h;
    logic [MAX_WIDTH-1:0]           col_mask;
    logic [MAX_WIDTH-1:0]           rd_row;
    logic [MAX_WIDTH-1:0]           lower_row;
    logic [MAX_WIDTH-1:0]           life_row;
    logic [MAX_WIDTH-1:0]           new_row;
    logic [MAX_WIDTH-1:0]           cell_wr_row;
    logic [SW-1:0]                  step_m2;
    logic                           cmd_fire;
    logic                           slot_free;
    logic                           cell_inside;
    logic                           rd_cell;

    logic                           mem_we;
    logic [RAW-1:0]                 mem_waddr;
    logic [MAX_WIDTH-1:0]           mem_wdata;
    logic                           mem_re;
    logic [RAW-1:0]                 mem_raddr;

    logic                           pop_clear;
    logic                           pop_in_valid;
    logic                           pop_busy;
    logic [CNT_W-1:0]               pop_total;

    // The block takes a command only between items; a finished response may still be
    // waiting in the response register at that time.
    assign cmd.ready = (state_reg == lge_pkg::ST_IDLE);
    assign cmd_fire  = cmd.valid & cmd.ready;
    assign slot_free = ~rsp_valid_reg | rsp.ready;

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.cell_alive = rsp_alive_reg;
    assign rsp.population = rsp_pop_reg;

    // Register values out of range are pulled back into 1..MAX.
    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = EW_W'(1);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            eff_w = EW_W'(MAX_WIDTH);
        end
        else
        begin
            eff_w = EW_W'(width_reg);
        end

        if (height_reg == '0)
        begin
            eff_h = EH_W'(1);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            eff_h = EH_W'(MAX_HEIGHT);
        end
        else
        begin
            eff_h = EH_W'(height_reg);
        end
    end

    always_comb
    begin
        for (int c = 0; c < MAX_WIDTH; c++)
        begin
            col_mask[c] = (c < 32'(eff_w));
        end
    end

    // Cell access: the row was read in the accept cycle and holds in rd_row.
    assign cell_inside = (32'(cmd_col_reg) < 32'(eff_w)) && (32'(cmd_row_reg) < 32'(eff_h));
    assign rd_cell     = cell_inside ? rd_row[CAW'(cmd_col_reg)] : 1'b0;

    always_comb
    begin
        cell_wr_row                     = rd_row;
        cell_wr_row[CAW'(cmd_col_reg)]  = cmd_alive_reg;
    end

    // Advance sweep. At step k the read of row k is launched, old row k-1 arrives as
    // the lower row, and the new row k-2 is written back. Rows outside the in-use area
    // enter the window as dead and are written back as dead.
    assign step_m2   = step_reg - SW'(2);
    assign lower_row = ((step_reg != '0) && (32'(step_reg) <= 32'(eff_h)))
                     ? (rd_row & col_mask) : '0;
    assign new_row   = (32'(step_reg) <= 32'(eff_h) + 32'd1) ? (life_row & col_mask) : '0;

    lge_next_row #(
        .WIDTH      (MAX_WIDTH)
    ) u_next_row (
        .upper      (upper_reg),
        .middle     (middle_reg),
        .lower      (lower_row),
        .next_cells (life_row)
    );

    lge_row_mem #(
        .DEPTH (MAX_HEIGHT),
        .WIDTH (MAX_WIDTH)
    ) u_row_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (rd_row)
    );

    lge_pop_count #(
        .WIDTH    (MAX_WIDTH),
        .CNT_W    (CNT_W)
    ) u_pop_count (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (pop_clear),
        .in_valid (pop_in_valid),
        .in_row   (new_row),
        .busy     (pop_busy),
        .total    (pop_total)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lge_pkg::ST_CLEAR:
            begin
                if (step_reg == LAST_CLEAR)
                begin
                    state_next = lge_pkg::ST_IDLE;
                end
            end
            lge_pkg::ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    if (lge_pkg::op_t'(cmd.operation) == lge_pkg::OP_ADVANCE)
                    begin
                        state_next = lge_pkg::ST_SWEEP;
                    end
                    else
                    begin
                        state_next = lge_pkg::ST_CELL;
                    end
                end
            end
            lge_pkg::ST_CELL:
            begin
                if (slot_free)
                begin
                    state_next = lge_pkg::ST_IDLE;
                end
            end
            lge_pkg::ST_SWEEP:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = lge_pkg::ST_DRAIN;
                end
            end
            lge_pkg::ST_DRAIN:
            begin
                if (!pop_busy && slot_free)
                begin
                    state_next = lge_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lge_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath control.
    always_comb
    begin
        step_next      = step_reg;
        live_cnt_next  = live_cnt_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp.ready;
        rsp_alive_next = rsp_alive_reg;
        rsp_pop_next   = rsp_pop_reg;
        upper_next     = upper_reg;
        middle_next    = middle_reg;
        mem_we         = 1'b0;
        mem_waddr      = step_reg[RAW-1:0];
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = RAW'(cmd.row);
        pop_clear      = 1'b0;
        pop_in_valid   = 1'b0;

        case (state_reg)
            lge_pkg::ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = step_reg[RAW-1:0];
                mem_wdata = '0;
                step_next = step_reg + SW'(1);
            end
            lge_pkg::ST_IDLE:
            begin
                step_next   = '0;
                upper_next  = '0;
                middle_next = '0;
                if (cmd_fire)
                begin
                    if (lge_pkg::op_t'(cmd.operation) == lge_pkg::OP_ADVANCE)
                    begin
                        pop_clear = 1'b1;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = RAW'(cmd.row);
                    end
                end
            end
            lge_pkg::ST_CELL:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_alive_next = 1'b0;
                    case (cmd_op_reg)
                        lge_pkg::OP_WRITE:
                        begin
                            if (cell_inside)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = RAW'(cmd_row_reg);
                                mem_wdata = cell_wr_row;
                                if (rd_cell && !cmd_alive_reg)
                                begin
                                    live_cnt_next = live_cnt_reg - CNT_W'(1);
                                end
                                else if (!rd_cell && cmd_alive_reg)
                                begin
                                    live_cnt_next = live_cnt_reg + CNT_W'(1);
                                end
                            end
                        end
                        lge_pkg::OP_READ:
                        begin
                            rsp_alive_next = rd_cell;
                        end
                        default:
                        begin
                            rsp_alive_next = 1'b0;
                        end
                    endcase
                    rsp_pop_next = (32'(live_cnt_next) > 32'(lge_pkg::POP_MAX))
                                 ? lge_pkg::POP_MAX : lge_pkg::POP_W'(live_cnt_next);
                end
            end
            lge_pkg::ST_SWEEP:
            begin
                mem_re      = (32'(step_reg) < MAX_HEIGHT);
                mem_raddr   = step_reg[RAW-1:0];
                upper_next  = middle_reg;
                middle_next = lower_row;
                step_next   = step_reg + SW'(1);
                if (step_reg >= SW'(2))
                begin
                    mem_we       = 1'b1;
                    mem_waddr    = step_m2[RAW-1:0];
                    mem_wdata    = new_row;
                    pop_in_valid = 1'b1;
                end
            end
            lge_pkg::ST_DRAIN:
            begin
                if (!pop_busy && slot_free)
                begin
                    live_cnt_next  = pop_total;
                    rsp_valid_next = 1'b1;
                    rsp_alive_next = 1'b0;
                    rsp_pop_next   = (32'(pop_total) > 32'(lge_pkg::POP_MAX))
                                   ? lge_pkg::POP_MAX : lge_pkg::POP_W'(pop_total);
                end
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lge_pkg::ST_CLEAR;
            step_reg      <= '0;
            live_cnt_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            width_reg     <= lge_pkg::DIM_RESET;
            height_reg    <= lge_pkg::DIM_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            live_cnt_reg  <= live_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                case (lge_pkg::cfg_idx_t'(cfg_index))
                    lge_pkg::CFG_WIDTH:  width_reg  <= cfg_data;
                    lge_pkg::CFG_HEIGHT: height_reg <= cfg_data;
                    default:
                    begin
                        width_reg <= width_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            cmd_op_reg    <= lge_pkg::op_t'(cmd.operation);
            cmd_col_reg   <= cmd.col;
            cmd_row_reg   <= cmd.row;
            cmd_alive_reg <= cmd.alive;
        end
        upper_reg     <= upper_next;
        middle_reg    <= middle_next;
        rsp_alive_reg <= rsp_alive_next;
        rsp_pop_reg   <= rsp_pop_next;
    end

endmodule

// ===== hw/rtl/lge_row_mem.sv =====
module lge_row_mem #(
    parameter int DEPTH = lge_pkg::MAX_HEIGHT_DEF,
    parameter int WIDTH = lge_pkg::MAX_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    // One grid row per entry, one write and one registered read per cycle.
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/lge_next_row.sv =====
module lge_next_row #(
    parameter int WIDTH = lge_pkg::MAX_WIDTH_DEF
) (
    input  logic [WIDTH-1:0] upper,
    input  logic [WIDTH-1:0] middle,
    input  logic [WIDTH-1:0] lower,
    output logic [WIDTH-1:0] next_cells
);

    // Pad one dead cell on each side so the edge columns see dead neighbors.
    logic [WIDTH+1:0] up_p;
    logic [WIDTH+1:0] mid_p;
    logic [WIDTH+1:0] low_p;

    assign up_p  = {1'b0, upper, 1'b0};
    assign mid_p = {1'b0, middle, 1'b0};
    assign low_p = {1'b0, lower, 1'b0};

    always_comb
    begin
        logic [3:0] n;
        n = '0;
        for (int c = 0; c < WIDTH; c++)
        begin
            n = 4'(up_p[c]) + 4'(up_p[c+1]) + 4'(up_p[c+2])
              + 4'(mid_p[c]) + 4'(mid_p[c+2])
              + 4'(low_p[c]) + 4'(low_p[c+1]) + 4'(low_p[c+2]);
            next_cells[c] = lge_pkg::life_rule(middle[c], n);
        end
    end

endmodule

// ===== hw/rtl/lge_pop_count.sv =====
module lge_pop_count #(
    parameter int WIDTH = lge_pkg::MAX_WIDTH_DEF,
    parameter int CNT_W = 13
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             clear,
    input  logic             in_valid,
    input  logic [WIDTH-1:0] in_row,
    output logic             busy,
    output logic [CNT_W-1:0] total
);

    localparam int NCH   = (WIDTH + lge_pkg::POP_CHUNK - 1) / lge_pkg::POP_CHUNK;
    localparam int PAD_W = NCH * lge_pkg::POP_CHUNK;

    logic                               row_vld_reg;
    logic                               chunk_vld_reg;
    logic [PAD_W-1:0]                   row_reg;
    logic [lge_pkg::POP_CHUNK_W-1:0]    chunk_cnt_reg [NCH];
    logic [CNT_W-1:0]                   total_reg;
    logic [CNT_W-1:0]                   chunk_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg   <= 1'b0;
            chunk_vld_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            row_vld_reg   <= in_valid;
            chunk_vld_reg <= row_vld_reg;
            if (clear)
            begin
                total_reg <= '0;
            end
            else if (chunk_vld_reg)
            begin
                total_reg <= total_reg + chunk_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= PAD_W'(in_row);
        for (int i = 0; i < NCH; i++)
        begin
            chunk_cnt_reg[i] <= lge_pkg::popcount_chunk(
                row_reg[i*lge_pkg::POP_CHUNK +: lge_pkg::POP_CHUNK]);
        end
    end

    always_comb
    begin
        chunk_sum = '0;
        for (int i = 0; i < NCH; i++)
        begin
            chunk_sum = chunk_sum + CNT_W'(chunk_cnt_reg[i]);
        end
    end

    assign busy  = row_vld_reg | chunk_vld_reg;
    assign total = total_reg;

endmodule

// ===== hw/rtl/lge_checker.sv =====
`include "life_generation_engine_unit_assert.svh"

module lge_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cmd_valid,
    input logic                      cmd_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic                      rsp_cell_alive,
    input logic [lge_pkg::POP_W-1:0] rsp_population
);

    // A stalled response beat stays offered and unchanged.
    `LGE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response beat dropped")
    `LGE_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready,
        $stable(rsp_cell_alive) && $stable(rsp_population), "stalled response changed")

    // Items are worked one at a time, so an accepted command closes the input.
    `LGE_ASSERT_NEXT(a_one_item, cmd_valid && cmd_ready, !cmd_ready,
        "command accepted while an item is at work")

    // A new response comes out of the working states and never out of the idle one.
    `LGE_ASSERT_SAME(a_rsp_from_work, $rose(rsp_valid), !$past(cmd_ready),
        "response appeared without an item at work")

endmodule

bind life_generation_engine_unit lge_checker u_lge_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_cell_alive (rsp.cell_alive),
    .rsp_population (rsp.population)
);
